@@ hw/rtl/pidr_pkg.sv @@
// ============================================================================
// pidr_pkg: shared types and constants of the fixed-point PID regulator
// Register map indexes, port widths and the pipeline depth of the core.
// ============================================================================
`timescale 1ns / 1ps

package pidr_pkg;

  // Fixed widths of the channel payload and of the register fields.
  localparam int unsigned IO_W       = 32;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned LIMIT_W    = 31;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = 3;

  // Number of register stages from input acceptance to the output register.
  localparam int unsigned PIPE_DEPTH = 3;

  // Register index, taken from paddr[4:2].
  typedef enum logic [REG_IDX_W-1:0] {
    REG_GAIN_PROP   = 3'd0,
    REG_GAIN_INTEG  = 3'd1,
    REG_GAIN_DERIV  = 3'd2,
    REG_SHIFT_PROP  = 3'd3,
    REG_SHIFT_INTEG = 3'd4,
    REG_SHIFT_DERIV = 3'd5,
    REG_DRIVE_LIMIT = 3'd6,
    REG_INTEG_LIMIT = 3'd7
  } reg_idx_t;

  typedef logic signed [IO_W-1:0] io_word_t;

endpackage

@@ hw/rtl/pidr_in_if.sv @@
// ============================================================================
// pidr_in_if: sample channel of the PID regulator
// Carries one word of target and feedback under a valid/ready handshake.
// ============================================================================
`timescale 1ns / 1ps

interface pidr_in_if
  import pidr_pkg::*;
  ();

  logic     valid;
  logic     ready;
  io_word_t target;
  io_word_t feedback;

  modport source (output valid, output target, output feedback, input ready);
  modport sink   (input valid, input target, input feedback, output ready);

endinterface

@@ hw/rtl/pidr_out_if.sv @@
// ============================================================================
// pidr_out_if: drive channel of the PID regulator
// Carries one drive word under a valid/ready handshake.
// ============================================================================
`timescale 1ns / 1ps

interface pidr_out_if
  import pidr_pkg::*;
  ();

  logic     valid;
  logic     ready;
  io_word_t drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);

endinterface

@@ hw/rtl/pid_regulator_fixed_point_core.sv @@
// ============================================================================
// pid_regulator_fixed_point_core: fixed-point PID regulator
// Three-stage pipeline: error differences, gain products, state update.
// ============================================================================
// The core takes one word per clock while the output side does not stall
// and returns one drive word for each. The output stage updates the
// integrator (positional law) or the accumulator (incremental law). In
// positional mode it does the add, clamp, one 16-bit gain multiply, a
// three-term sum, the saturation compare and the final clamp; in incremental
// mode a four-term sum and the clamp. Error differences and the other gain
// products are formed in the two stages before it. POSITIONAL_MODE selects
// the law and DATA_WIDTH the width at which differences and sums wrap; the
// ports stay 32 bits wide and the drive is sign-extended. Registers must be
// written over the APB port only while no word is in flight; the core itself does not enforce this.
`timescale 1ns / 1ps

module pid_regulator_fixed_point_core
  import pidr_pkg::*;
#(
  parameter int unsigned POSITIONAL_MODE = 1,
  parameter int unsigned DATA_WIDTH      = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  pidr_in_if.sink               in_ch,
  pidr_out_if.source            out_ch
);

  localparam int unsigned PROD_W = GAIN_W + DATA_WIDTH;
  localparam int unsigned CMP_W  = LIMIT_W + 2;

  typedef logic signed [DATA_WIDTH-1:0] dword_t;
  typedef logic signed [CMP_W-1:0]      cword_t;

  // Gain product, floor-shifted, reduced to the data width.
  function automatic dword_t scaled(input logic signed [GAIN_W-1:0] g,
                                    input dword_t x,
                                    input logic [SHIFT_W-1:0] s);
    logic signed [PROD_W-1:0] p;
    p = PROD_W'(g) * PROD_W'(x);
    p = p >>> s;
    return p[DATA_WIDTH-1:0];
  endfunction

  // Symmetric clamp of a data word to a 31-bit limit.
  function automatic dword_t clamp_sym(input dword_t v, input logic [LIMIT_W-1:0] lim);
    cword_t vx;
    cword_t lx;
    cword_t nx;
    vx = CMP_W'(v);
    lx = cword_t'({2'b00, lim});
    nx = -lx;
    if (vx > lx) begin
      return lx[DATA_WIDTH-1:0];
    end else if (vx < nx) begin
      return nx[DATA_WIDTH-1:0];
    end
    return v;
  endfunction

  // Configuration registers.
  logic signed [GAIN_W-1:0] gain_prop_r, gain_integ_r, gain_deriv_r;
  logic [SHIFT_W-1:0]       shift_prop_r, shift_integ_r, shift_deriv_r;
  logic [LIMIT_W-1:0]       drive_limit_r, integ_limit_r;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  // Register writes on the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_prop_r   <= '0;
      gain_integ_r  <= '0;
      gain_deriv_r  <= '0;
      shift_prop_r  <= '0;
      shift_integ_r <= '0;
      shift_deriv_r <= '0;
      drive_limit_r <= '0;
      integ_limit_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GAIN_PROP:   gain_prop_r   <= pwdata[GAIN_W-1:0];
        REG_GAIN_INTEG:  gain_integ_r  <= pwdata[GAIN_W-1:0];
        REG_GAIN_DERIV:  gain_deriv_r  <= pwdata[GAIN_W-1:0];
        REG_SHIFT_PROP:  shift_prop_r  <= pwdata[SHIFT_W-1:0];
        REG_SHIFT_INTEG: shift_integ_r <= pwdata[SHIFT_W-1:0];
        REG_SHIFT_DERIV: shift_deriv_r <= pwdata[SHIFT_W-1:0];
        REG_DRIVE_LIMIT: drive_limit_r <= pwdata[LIMIT_W-1:0];
        REG_INTEG_LIMIT: integ_limit_r <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback; gains read back sign-extended.
  always_comb begin
    case (cfg_idx)
      REG_GAIN_PROP:   prdata = APB_DATA_W'(gain_prop_r);
      REG_GAIN_INTEG:  prdata = APB_DATA_W'(gain_integ_r);
      REG_GAIN_DERIV:  prdata = APB_DATA_W'(gain_deriv_r);
      REG_SHIFT_PROP:  prdata = APB_DATA_W'(shift_prop_r);
      REG_SHIFT_INTEG: prdata = APB_DATA_W'(shift_integ_r);
      REG_SHIFT_DERIV: prdata = APB_DATA_W'(shift_deriv_r);
      REG_DRIVE_LIMIT: prdata = APB_DATA_W'(drive_limit_r);
      REG_INTEG_LIMIT: prdata = APB_DATA_W'(integ_limit_r);
      default:         prdata = '0;
    endcase
  end

  // Pipeline flow control: each stage moves when the next one is free or moving.
  logic v1_r, v2_r, out_valid_r;
  logic move_out, move2, in_ready, in_acc;

  assign move_out = v2_r && (!out_valid_r || out_ch.ready);
  assign move2    = v1_r && (!v2_r || move_out);
  assign in_ready = !v1_r || move2;
  assign in_acc   = in_ch.valid && in_ready;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= in_acc || (v1_r && !move2);
      v2_r        <= move2 || (v2_r && !move_out);
      out_valid_r <= move_out || (out_valid_r && !out_ch.ready);
    end
  end

  // Stage 1: error and its first and second differences.
  dword_t tgt_w, fb_w, err_c, derr_c, d2err_c;
  dword_t last_err_r, last_delta_r;
  dword_t err1_r, derr1_r, d2err1_r;

  always_comb begin
    tgt_w   = in_ch.target[DATA_WIDTH-1:0];
    fb_w    = in_ch.feedback[DATA_WIDTH-1:0];
    err_c   = tgt_w - fb_w;
    derr_c  = err_c - last_err_r;
    d2err_c = derr_c - last_delta_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r   <= '0;
      last_delta_r <= '0;
    end else if (in_acc) begin
      last_err_r   <= err_c;
      last_delta_r <= derr_c;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      err1_r   <= err_c;
      derr1_r  <= derr_c;
      d2err1_r <= d2err_c;
    end
  end

  // Stage 2: gain products that do not depend on the integrator.
  // Positional: P on error, D on first difference, and the integral term of
  // the error alone for back-integration. Incremental: P on first difference,
  // D on second difference, I on error.
  dword_t ta_c, tb_c, tc_c;
  dword_t ta_r, tb_r, tc_r, err2_r;

  always_comb begin
    if (POSITIONAL_MODE != 0) begin
      ta_c = scaled(gain_prop_r, err1_r, shift_prop_r);
      tb_c = scaled(gain_deriv_r, derr1_r, shift_deriv_r);
    end else begin
      ta_c = scaled(gain_prop_r, derr1_r, shift_prop_r);
      tb_c = scaled(gain_deriv_r, d2err1_r, shift_deriv_r);
    end
    tc_c = scaled(gain_integ_r, err1_r, shift_integ_r);
  end

  always_ff @(posedge clk) begin
    if (move2) begin
      ta_r   <= ta_c;
      tb_r   <= tb_c;
      tc_r   <= tc_c;
      err2_r <= err1_r;
    end
  end

  // Stage 3: integrator or accumulator update, saturation and drive clamp.
  dword_t accum_r, accum_nxt;
  dword_t drive_c;
  dword_t es_sum, es_clamp, ti_c, drive_raw, drive_back, acc_sum;
  cword_t drv_x, lim_x;
  logic   back;
  io_word_t drive_r;

  always_comb begin
    es_sum     = accum_r + err2_r;
    es_clamp   = (integ_limit_r == '0) ? es_sum : clamp_sym(es_sum, integ_limit_r);
    ti_c       = scaled(gain_integ_r, es_clamp, shift_integ_r);
    drive_raw  = ta_r + ti_c + tb_r;
    drive_back = drive_raw - tc_r;
    drv_x      = CMP_W'(drive_raw);
    lim_x      = cword_t'({2'b00, drive_limit_r});
    back       = ((drv_x > lim_x) && (err2_r > 0)) || ((drv_x < -lim_x) && (err2_r < 0));
    acc_sum    = accum_r + ta_r + tb_r + tc_r;

    if (POSITIONAL_MODE != 0) begin
      accum_nxt = es_clamp;
      drive_c   = drive_raw;
      if (drive_limit_r != '0) begin
        // Saturated in the error's direction: take the step back out.
        if (back) begin
          accum_nxt = es_clamp - err2_r;
          drive_c   = clamp_sym(drive_back, drive_limit_r);
        end else begin
          drive_c   = clamp_sym(drive_raw, drive_limit_r);
        end
      end
    end else begin
      accum_nxt = clamp_sym(acc_sum, drive_limit_r);
      drive_c   = accum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
    end else if (move_out) begin
      accum_r <= accum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move_out) begin
      drive_r <= IO_W'(drive_c);
    end
  end

  assign out_ch.drive = drive_r;

endmodule

@@ hw/rtl/pidr_checker.sv @@
// ============================================================================
// pidr_checker: port-level checks of the PID regulator core
// Tracks words in flight and checks flow control at both ports.
// ============================================================================
`timescale 1ns / 1ps

module pidr_checker
  import pidr_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [IO_W-1:0] out_drive
);

  logic       in_acc, out_acc;
  logic [2:0] inflight_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Words accepted and not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + 3'(in_acc) - 3'(out_acc);
    end
  end

  // No drive word is shown without a sample behind it.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (inflight_r != 3'd0))
    else $error("drive word shown with no sample in flight");

  // The pipeline never holds more words than it has stages.
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 3'(PIPE_DEPTH))
    else $error("more words in flight than pipeline stages");

  // An empty core always takes a sample.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (inflight_r == 3'd0) |-> in_ready)
    else $error("empty core refused a sample");

  // A stalled drive word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_drive)))
    else $error("stalled drive word changed or dropped");

endmodule

bind pid_regulator_fixed_point_core pidr_checker u_pidr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_drive (out_ch.drive)
);

@@ test/tb_pid_regulator_fixed_point_core.sv @@
// ============================================================================
// tb_pid_regulator_fixed_point_core: self-checking bench of the PID core
// Drives target/feedback words through the sample channel, keeps a local
// model of the regulator law and its state, and checks every drive word in
// order. Gains, shifts and limits are reprogrammed over APB between phases
// while the core is idle, under several idling and back-pressure patterns.
// ============================================================================
`timescale 1ns / 1ps

module tb_pid_regulator_fixed_point_core;
  import pidr_pkg::*;

  localparam int unsigned POS_MODE = 1;
  localparam int unsigned DW       = 32;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 96;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_WORDS  = 160;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    io_word_t target;
    io_word_t feedback;
  } sample_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gp;
    logic signed [GAIN_W-1:0] gi;
    logic signed [GAIN_W-1:0] gd;
    logic [SHIFT_W-1:0]       sp;
    logic [SHIFT_W-1:0]       si;
    logic [SHIFT_W-1:0]       sd;
    logic [LIMIT_W-1:0]       dl;
    logic [LIMIT_W-1:0]       il;
  } coef_set_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  pidr_in_if  in_ch ();
  pidr_out_if out_ch ();

  pid_regulator_fixed_point_core #(
    .POSITIONAL_MODE (POS_MODE),
    .DATA_WIDTH      (DW)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  // Words waiting to be sent and drive words still owed by the core.
  sample_t          sample_q[$];
  logic [IO_W-1:0]  drive_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  bit in_fire        = 1'b0;
  int hold_req       = 0;
  int hold_ack       = 0;
  int hold_left      = 0;

  // Local copy of the register file and of the regulator state.
  coef_set_t coef = '0;
  longint prev_err  = 0;
  longint prev_derr = 0;
  longint incr_acc  = 0;
  longint integ_sum = 0;

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Reduce a value to DW-bit two's complement.
  function automatic longint wrap_dw(input longint v);
    longint m;
    m = v <<< (64 - DW);
    return m >>> (64 - DW);
  endfunction

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Full-width gain product, floor-shifted right.
  function automatic longint scaled(input longint gain, input longint x,
                                    input logic [SHIFT_W-1:0] s);
    return (gain * x) >>> s;
  endfunction

  // One regulator step: updates the local state and returns the drive word.
  function automatic logic [IO_W-1:0] regulate_step(input io_word_t tgt,
                                                     input io_word_t fbk);
    longint e, de, d2e, u, lim_d, lim_i;
    e     = wrap_dw(wrap_dw(longint'(tgt)) - wrap_dw(longint'(fbk)));
    de    = wrap_dw(e - prev_err);
    lim_d = longint'(coef.dl);
    lim_i = longint'(coef.il);
    if (POS_MODE != 0) begin
      integ_sum = wrap_dw(integ_sum + e);
      if (lim_i != 0) integ_sum = clamp_sym(integ_sum, lim_i);
      u = wrap_dw(scaled(coef.gp, e, coef.sp) + scaled(coef.gi, integ_sum, coef.si)
                  + scaled(coef.gd, de, coef.sd));
      prev_err = e;
      // A zero drive limit turns off both back-integration and the clamp.
      if (lim_d != 0) begin
        if ((u > lim_d && e > 0) || (u < -lim_d && e < 0)) begin
          integ_sum = wrap_dw(integ_sum - e);
          u = wrap_dw(u - scaled(coef.gi, e, coef.si));
        end
        u = clamp_sym(u, lim_d);
      end
    end else begin
      d2e = wrap_dw(de - prev_derr);
      u = wrap_dw(incr_acc + scaled(coef.gp, de, coef.sp) + scaled(coef.gi, e, coef.si)
                  + scaled(coef.gd, d2e, coef.sd));
      incr_acc  = clamp_sym(u, lim_d);
      prev_err  = e;
      prev_derr = de;
      u = incr_acc;
    end
    return u[IO_W-1:0];
  endfunction

  // Sender: offers the next queued word once the current one is taken.
  always @(negedge clk) begin : sample_driver
    sample_t s;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s = sample_q.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.target   <= s.target;
        in_ch.feedback <= s.feedback;
      end else begin
        in_ch.valid    <= 1'b0;
        in_ch.target   <= $urandom();
        in_ch.feedback <= $urandom();
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin : drive_receiver
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on each accepted sample and checks each drive word.
  always @(posedge clk) begin : drive_monitor
    logic [IO_W-1:0] want;
    if (!rst_n) begin
      in_fire = 1'b0;
    end else begin
      in_fire = in_ch.valid && in_ch.ready;
      if (in_fire) drive_q.push_back(regulate_step(in_ch.target, in_ch.feedback));
      if (out_ch.valid && out_ch.ready) begin
        if (drive_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected drive word, expected none, actual %h",
                   $time, out_ch.drive);
        end else begin
          want = drive_q.pop_front();
          if (out_ch.drive !== want) begin
            mismatches++;
            $display("%0t: drive mismatch, expected %h, actual %h",
                     $time, want, out_ch.drive);
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // APB write: setup cycle, then access cycle until pready.
  task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_GAIN_PROP:   coef.gp = data[GAIN_W-1:0];
      REG_GAIN_INTEG:  coef.gi = data[GAIN_W-1:0];
      REG_GAIN_DERIV:  coef.gd = data[GAIN_W-1:0];
      REG_SHIFT_PROP:  coef.sp = data[SHIFT_W-1:0];
      REG_SHIFT_INTEG: coef.si = data[SHIFT_W-1:0];
      REG_SHIFT_DERIV: coef.sd = data[SHIFT_W-1:0];
      REG_DRIVE_LIMIT: coef.dl = data[LIMIT_W-1:0];
      REG_INTEG_LIMIT: coef.il = data[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Writes all eight registers; unused upper data bits carry random junk.
  task automatic program_regs(input coef_set_t c);
    logic [APB_DATA_W-1:0] junk;
    junk = $urandom();
    apb_write(REG_GAIN_PROP,   {junk[31:16], c.gp});
    apb_write(REG_GAIN_INTEG,  {junk[15:0], c.gi});
    apb_write(REG_GAIN_DERIV,  {junk[23:8], c.gd});
    apb_write(REG_SHIFT_PROP,  {junk[26:0], c.sp});
    apb_write(REG_SHIFT_INTEG, {junk[31:5], c.si});
    apb_write(REG_SHIFT_DERIV, {junk[28:2], c.sd});
    apb_write(REG_DRIVE_LIMIT, {junk[7], c.dl});
    apb_write(REG_INTEG_LIMIT, {junk[19], c.il});
  endtask

  task automatic set_idling(input idle_mode_t m);
    case (m)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 75; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 75; end
      default:       begin send_idle_pct = 14; recv_stall_pct = 14; end
    endcase
  endtask

  // Waits until every word has been sent and answered, then lets the
  // pipeline settle before the registers are touched.
  task automatic wait_drained();
    while (sample_q.size() != 0 || in_ch.valid || drive_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic add_sample(input io_word_t t, input io_word_t f);
    sample_q.push_back('{target: t, feedback: f});
  endtask

  // Random target with the feedback placed to give error e.
  task automatic add_err(input io_word_t e);
    io_word_t t;
    t = $urandom();
    add_sample(t, t - e);
  endtask

  function automatic logic signed [GAIN_W-1:0] rand_gain();
    int g;
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return -16'sd1;
        endcase
      end
      1: begin
        g = $urandom_range(0, 128);
        return GAIN_W'(g - 64);
      end
      default: return GAIN_W'($urandom());
    endcase
  endfunction

  function automatic logic [SHIFT_W-1:0] rand_shift();
    if ($urandom_range(0, 1) != 0) return SHIFT_W'($urandom_range(0, 12));
    return SHIFT_W'($urandom_range(0, 31));
  endfunction

  function automatic logic [LIMIT_W-1:0] rand_limit();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return LIMIT_W'(1);
      2, 3: return LIMIT_W'($urandom_range(2, 100000));
      4: return LIMIT_W'($urandom());
      default: return '1;
    endcase
  endfunction

  // Mostly runs of similar error so the integrator builds up and the drive
  // saturates; the rest is unrelated noise and corner words.
  task automatic load_random_phase(input int n);
    io_word_t corners[5];
    io_word_t err_base, t;
    int run_left, jit, mag, i;
    corners = '{32'sh7fffffff, 32'sh80000000, 32'sh0, 32'sh1, -32'sh1};
    run_left = 0;
    err_base = '0;
    for (i = 0; i < n; i++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(3, 24);
        case ($urandom_range(0, 3))
          0: mag = $urandom_range(0, 16);
          1: mag = $urandom_range(0, 4096);
          2: mag = $urandom_range(0, 1 << 20);
          default: mag = $urandom();
        endcase
        if ($urandom_range(0, 1) != 0) mag = -mag;
        err_base = mag;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          jit = $urandom_range(0, 6);
          jit = jit - 3;
          t = $urandom();
          add_sample(t, t - err_base - jit);
          run_left--;
        end
        7, 8: add_sample($urandom(), $urandom());
        default: add_sample(corners[$urandom_range(0, 4)], corners[$urandom_range(0, 4)]);
      endcase
    end
  endtask

  // Stimulus sequence.
  initial begin : stimulus
    coef_set_t c;
    int p;
    in_ch.valid    = 1'b0;
    in_ch.target   = '0;
    in_ch.feedback = '0;
    out_ch.ready   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Register defaults after reset: all gains zero.
    set_idling(IDLE_BOTH);
    add_sample(32'sh7fffffff, 32'sh80000000);
    add_sample(32'sh80000000, 32'sh7fffffff);
    wait_drained();

    // Unit gains, no drive clamp and no integrator clamp: raw wrapped sum,
    // with errors that wrap at the data width.
    c = '{gp: 16'sd1, gi: 16'sd1, gd: 16'sd1, sp: 5'd0, si: 5'd0, sd: 5'd0,
          dl: '0, il: '0};
    program_regs(c);
    add_sample(32'sh0, 32'sh0);
    add_sample(32'sh7fffffff, 32'sh80000000);
    add_sample(32'sh80000000, 32'sh7fffffff);
    add_sample(-32'sh1, 32'sh0);
    add_err(32'sd1000);
    add_err(32'sd1000);
    wait_drained();

    // Extreme gains, shifts and limits.
    c = '{gp: 16'sh7fff, gi: 16'sh8000, gd: 16'sh8000, sp: 5'd0, si: 5'd31, sd: 5'd15,
          dl: '1, il: '1};
    program_regs(c);
    add_sample(32'sh7fffffff, 32'sh80000000);
    add_sample(32'sh80000000, 32'sh7fffffff);
    add_sample(32'sh7fffffff, 32'sh0);
    wait_drained();

    // Integrator clamp, then saturation in both directions with
    // back-integration.
    c = '{gp: 16'sd64, gi: 16'sd16, gd: 16'sd8, sp: 5'd4, si: 5'd2, sd: 5'd3,
          dl: 31'd5000, il: 31'd700};
    program_regs(c);
    repeat (3) add_err(32'sd300);
    repeat (2) add_err(32'sd2000);
    repeat (3) add_err(-32'sd2000);
    add_err(32'sd0);
    wait_drained();

    // Random phases over all idling patterns.
    for (p = 0; p < RAND_PHASES; p++) begin
      set_idling(idle_mode_t'(p % 4));
      c = '{gp: rand_gain(), gi: rand_gain(), gd: rand_gain(),
            sp: rand_shift(), si: rand_shift(), sd: rand_shift(),
            dl: rand_limit(), il: rand_limit()};
      program_regs(c);
      load_random_phase(PHASE_WORDS);
      // Long receiver hold-off while the sender keeps offering words.
      if (p == 4) begin
        @(posedge clk);
        hold_req++;
      end
      wait_drained();
    end

    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/pidr_pkg.sv
hw/rtl/pidr_in_if.sv
hw/rtl/pidr_out_if.sv
hw/rtl/pid_regulator_fixed_point_core.sv
hw/rtl/pidr_checker.sv
test/tb_pid_regulator_fixed_point_core.sv
